// File: hw/rtl/receive_window_nack_tracker_top_defines.svh
// assertion macros for the receive window nack tracker
`ifndef RECEIVE_WINDOW_NACK_TRACKER_TOP_DEFINES_SVH
`define RECEIVE_WINDOW_NACK_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// checked property, quiet while reset is held
`define RWNT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rwnt check failed");
// checked property, also watched around reset
`define RWNT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rwnt check failed");
`else
`define RWNT_ASSERT(lbl, prop)
`define RWNT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/rwnt_pkg.sv
// shared types and constants of the receive window nack tracker
package rwnt_pkg;

  localparam int SEQ_W  = 31;
  localparam int TIME_W = 32;
  localparam int HIST_W = 31;

  localparam logic [HIST_W-1:0] HIST_RESET = 31'd500000;
  localparam logic [SEQ_W-1:0]  SEQ_MAX    = {SEQ_W{1'b1}};

  // result kinds
  localparam logic [2:0] KIND_NACK     = 3'd0;
  localparam logic [2:0] KIND_DELIVER  = 3'd1;
  localparam logic [2:0] KIND_DROP_OLD = 3'd2;
  localparam logic [2:0] KIND_DROP_DUP = 3'd3;
  localparam logic [2:0] KIND_DROP_LEN = 3'd4;

  // register index of the history time
  localparam logic [0:0] REG_HISTORY = 1'b0;

  // one queued packet, classified by length check
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic              len_bad;
    logic [TIME_W-1:0] now;
  } item_t;

  // status from the back end to the front end
  typedef struct packed {
    logic init_done;
    logic take;
  } back_stat_t;

endpackage

// File: hw/rtl/rwnt_front.sv
// front end: accepts packets, flags bad lengths, two entry queue
module rwnt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [30:0]         in_seq_number,
  input  logic                in_length_matches,
  input  logic [31:0]         in_now_us,
  input  rwnt_pkg::back_stat_t stat,
  output logic                q_valid,
  output rwnt_pkg::item_t     q_item
);

  rwnt_pkg::item_t slot_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       wr_r;
  logic       push;
  logic       pop;

  assign in_ready = stat.init_done && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && stat.take;
  assign q_item   = slot_r[rd_r];

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // queue storage with the length classification
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r].seq     <= in_seq_number;
      slot_r[wr_r].len_bad <= ~in_length_matches;
      slot_r[wr_r].now     <= in_now_us;
    end
  end

endmodule

// File: hw/rtl/rwnt_back.sv
// back end: window walk, cell clearing, nack and result sequencing
module rwnt_back #(
  parameter int WINDOW_DEPTH = 256,
  parameter int NACK_MAX     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [30:0]          hist_us,
  input  logic                 q_valid,
  input  rwnt_pkg::item_t      q_item,
  output rwnt_pkg::back_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_kind,
  output logic [30:0]          out_result_seq,
  output logic                 out_last
);

  localparam int  LW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int  CW      = $clog2(WINDOW_DEPTH + 1);
  localparam int  NW      = $clog2(NACK_MAX + 1);
  localparam bit  IS_POW2 = ((1 << LW) == WINDOW_DEPTH);
  localparam logic [LW-1:0] IDX_LAST  = LW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);
  localparam logic [30:0]   DEPTH_S   = 31'(WINDOW_DEPTH);
  localparam logic [30:0]   DEPTH_M1  = 31'(WINDOW_DEPTH - 1);
  localparam logic [NW-1:0] NMAX      = NW'(NACK_MAX);
  localparam logic [30:0]   NMAX_S    = 31'(NACK_MAX);
  localparam logic [31:0]   RECIP     = 32'((64'd1 << 32) / WINDOW_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_MOD_FIX, S_CLASS, S_DUP, S_EXP_RD, S_EXP_CHK, S_JUMP,
    S_GAP, S_CLR, S_NACK, S_DELIV, S_DROP
  } state_t;

  typedef struct packed {
    logic        recv;
    logic [31:0] stamp;
  } cell_t;

  state_t          state_r, ret_r;
  rwnt_pkg::item_t item_r;
  logic [LW-1:0]   seq_idx_r;
  logic [30:0]     quo_r;
  logic [30:0]     tail_r, head_r, i_r;
  logic [LW-1:0]   tail_idx_r, head_idx_r, i_idx_r, clr_ptr_r;
  logic [CW-1:0]   clr_cnt_r;
  logic [NW-1:0]   k_r, ncnt_r;
  logic [2:0]      kind_r;
  logic            init_done_r;
  logic            out_valid_r;
  logic [2:0]      out_kind_r;
  logic [30:0]     out_seq_r;
  logic            out_last_r;

  cell_t           mem [WINDOW_DEPTH];
  cell_t           rd_data_r;
  logic            mem_we;
  logic [LW-1:0]   mem_waddr;
  cell_t           mem_wdata;
  logic [LW-1:0]   rd_addr;

  logic            emit_ok;
  logic [31:0]     age;
  logic            expired;
  logic [62:0]     quo_prod;
  logic [30:0]     rem_est;
  logic [30:0]     gap;
  logic [30:0]     new_tail;

  function automatic logic [LW-1:0] inc_idx(input logic [LW-1:0] x);
    inc_idx = (x == IDX_LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [CW-1:0] span_cnt(input logic [30:0] d);
    span_cnt = (d >= DEPTH_S) ? DEPTH_C : d[CW-1:0];
  endfunction

  assign emit_ok  = !out_valid_r || out_ready;
  assign age      = item_r.now - rd_data_r.stamp;
  assign expired  = !age[31] && (age[30:0] > hist_us);
  // quotient estimate by reciprocal, at most one below the true quotient
  assign quo_prod = 63'(item_r.seq) * 63'(RECIP);
  assign rem_est  = item_r.seq - 31'(quo_r * DEPTH_S);
  assign gap      = item_r.seq - head_r;
  assign new_tail = item_r.seq - DEPTH_M1;

  assign stat.init_done = init_done_r;
  assign stat.take      = (state_r == S_IDLE);

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_result_seq = out_seq_r;
  assign out_last       = out_last_r;

  // memory port selection
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = clr_ptr_r;
    mem_wdata.recv  = 1'b0;
    mem_wdata.stamp = item_r.now;
    rd_addr         = (state_r == S_CLASS) ? seq_idx_r : i_idx_r;
    case (state_r)
      S_CLR: mem_we = 1'b1;
      S_EXP_CHK: begin
        mem_we    = rd_data_r.recv && expired;
        mem_waddr = i_idx_r;
      end
      S_DELIV: begin
        mem_we         = emit_ok;
        mem_waddr      = seq_idx_r;
        mem_wdata.recv = 1'b1;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // cell memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ret_r       <= S_IDLE;
      clr_ptr_r   <= '0;
      clr_cnt_r   <= DEPTH_C;
      init_done_r <= 1'b0;
      tail_r      <= '0;
      head_r      <= '0;
      tail_idx_r  <= '0;
      head_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r <= q_item;
            if (q_item.len_bad) begin
              kind_r  <= rwnt_pkg::KIND_DROP_LEN;
              state_r <= S_DROP;
            end else if (IS_POW2) begin
              seq_idx_r <= q_item.seq[LW-1:0];
              state_r   <= S_CLASS;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        // remainder by reciprocal multiply, then one correction
        S_MOD: begin
          quo_r   <= quo_prod[62:32];
          state_r <= S_MOD_FIX;
        end
        S_MOD_FIX: begin
          if (rem_est >= DEPTH_S) seq_idx_r <= LW'(rem_est - DEPTH_S);
          else seq_idx_r <= rem_est[LW-1:0];
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          i_r     <= tail_r;
          i_idx_r <= tail_idx_r;
          if (item_r.seq < tail_r) begin
            kind_r  <= rwnt_pkg::KIND_DROP_OLD;
            state_r <= S_DROP;
          end else if (item_r.seq < head_r) begin
            state_r <= S_DUP;
          end else begin
            state_r <= S_EXP_RD;
          end
        end
        S_DUP: begin
          if (rd_data_r.recv) begin
            kind_r  <= rwnt_pkg::KIND_DROP_DUP;
            state_r <= S_DROP;
          end else begin
            state_r <= S_EXP_RD;
          end
        end
        // expiry walk from the tail
        S_EXP_RD: begin
          state_r <= (i_r < head_r) ? S_EXP_CHK : S_JUMP;
        end
        S_EXP_CHK: begin
          if (!rd_data_r.recv || expired) begin
            if (rd_data_r.recv) begin
              tail_r     <= i_r + 31'd1;
              tail_idx_r <= inc_idx(i_idx_r);
            end
            i_r     <= i_r + 31'd1;
            i_idx_r <= inc_idx(i_idx_r);
            state_r <= S_EXP_RD;
          end else begin
            state_r <= S_JUMP;
          end
        end
        // keep the window within its depth
        S_JUMP: begin
          if (item_r.seq >= head_r) begin
            if ((item_r.seq - tail_r) >= DEPTH_S) begin
              clr_ptr_r  <= tail_idx_r;
              clr_cnt_r  <= span_cnt(new_tail - tail_r);
              tail_r     <= new_tail;
              tail_idx_r <= inc_idx(seq_idx_r);
              ret_r      <= S_GAP;
              state_r    <= S_CLR;
            end else begin
              state_r <= S_GAP;
            end
          end else begin
            state_r <= S_DELIV;
          end
        end
        // clear the skipped cells, set up the nack count
        S_GAP: begin
          k_r    <= '0;
          ncnt_r <= (gap >= NMAX_S) ? NMAX : gap[NW-1:0];
          if (gap != 31'd0) begin
            clr_ptr_r <= head_idx_r;
            clr_cnt_r <= span_cnt(gap);
            ret_r     <= S_NACK;
            state_r   <= S_CLR;
          end else begin
            state_r <= S_NACK;
          end
        end
        S_CLR: begin
          clr_ptr_r <= inc_idx(clr_ptr_r);
          clr_cnt_r <= clr_cnt_r - 1'b1;
          if (clr_cnt_r == CW'(1)) begin
            state_r <= ret_r;
            if (ret_r == S_IDLE) init_done_r <= 1'b1;
          end
        end
        S_NACK: begin
          if (k_r < ncnt_r) begin
            if (emit_ok) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= rwnt_pkg::KIND_NACK;
              out_seq_r   <= head_r + 31'(k_r);
              out_last_r  <= 1'b0;
              k_r         <= k_r + 1'b1;
            end
          end else begin
            head_r     <= item_r.seq + 31'd1;
            head_idx_r <= (item_r.seq == rwnt_pkg::SEQ_MAX) ? '0 : inc_idx(seq_idx_r);
            state_r    <= S_DELIV;
          end
        end
        S_DELIV: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= rwnt_pkg::KIND_DELIVER;
            out_seq_r   <= item_r.seq;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DROP: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            out_seq_r   <= item_r.seq;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/receive_window_nack_tracker_top.sv
// top level of the receive window nack tracker
// Packets enter on the in_ beat channel (sequence number, length flag, time
// in microseconds) and results leave on the out_ beat channel, each with a
// kind, a sequence number and a last flag closing the packet's results.
// A packet gives one drop result, or up to NACK_MAX nacks and a deliver.
// history_time_us sits at byte address 0 of the APB-style port.
// A two entry queue decouples input from the sequencer, and a result
// register decouples the sequencer from the receiver.
// A bad length goes straight to its drop result; an old packet is dropped
// after classification, and a duplicate after its cell is read. A deliver
// runs the expiry scan from the tail until it stops on a recent cell,
// clears the skipped cells (at most WINDOW_DEPTH per clear span), sends
// its nacks and then the deliver result. A depth that is no power of two
// adds a reciprocal remainder step for the sequence number.
// After reset a clearing pass over all WINDOW_DEPTH cells empties the cell
// memory; in_ready stays low until it ends. Configuration is still taken.
// A stalled receiver holds the result register; the sequencer waits on it
// while the queue keeps taking up to two packets.
`include "receive_window_nack_tracker_top_defines.svh"
module receive_window_nack_tracker_top #(
  parameter int WINDOW_DEPTH = 256,
  parameter int NACK_MAX     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_seq_number,
  input  logic        in_length_matches,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [30:0] out_result_seq,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0]          hist_r;
  logic                 q_valid;
  rwnt_pkg::item_t      q_item;
  rwnt_pkg::back_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr == rwnt_pkg::REG_HISTORY) ? {1'b0, hist_r} : 32'd0;

  // history time register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= rwnt_pkg::HIST_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == rwnt_pkg::REG_HISTORY) begin
      hist_r <= pwdata[30:0];
    end
  end

  rwnt_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_seq_number     (in_seq_number),
    .in_length_matches (in_length_matches),
    .in_now_us         (in_now_us),
    .stat              (stat),
    .q_valid           (q_valid),
    .q_item            (q_item)
  );

  rwnt_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .NACK_MAX     (NACK_MAX)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .hist_us        (hist_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_result_seq (out_result_seq),
    .out_last       (out_last)
  );

  // only nacks leave a packet open
  `RWNT_ASSERT(a_open_is_nack, out_valid && !out_last |-> out_kind == rwnt_pkg::KIND_NACK)
  `RWNT_ASSERT(a_nack_not_last, out_valid && out_kind == rwnt_pkg::KIND_NACK |-> !out_last)
  // in_ready is low once reset has been held, as the clearing pass starts
  `RWNT_ASSERT_ALWAYS(a_reset_blocks, !rst_n |=> !in_ready)

endmodule
